FILE: sv/ura_pkg.sv
// Shared constants, types and helpers for the ultrasonic ranger with median alert.
`timescale 1ns / 1ps

package ura_pkg;

  // Field widths
  localparam int DIST_W = 11;
  localparam int THR_W  = 9;
  localparam int TMO_W  = 16;
  localparam int BEEP_W = 10;
  localparam int ZONE_W = 3;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Timing constants
  localparam int US_PER_CM       = 58;
  localparam int TICKS_PER_MS    = 1000;
  localparam int SAMPLES         = 3;
  localparam int TRIG_LOW_TICKS  = 2;
  localparam int TRIG_HIGH_TICKS = 10;
  localparam int SUB_W           = $clog2(US_PER_CM);
  localparam int US_W            = $clog2(TICKS_PER_MS);

  // Sequencer phases
  localparam logic [2:0] PH_TRIG_LOW  = 3'd0;
  localparam logic [2:0] PH_TRIG_HIGH = 3'd1;
  localparam logic [2:0] PH_WAIT_RISE = 3'd2;
  localparam logic [2:0] PH_MEASURE   = 3'd3;
  localparam logic [2:0] PH_BEEP      = 3'd4;

  // Zone codes
  localparam logic [ZONE_W-1:0] ZONE_ERR      = 3'd0;
  localparam logic [ZONE_W-1:0] ZONE_FAR      = 3'd1;
  localparam logic [ZONE_W-1:0] ZONE_LONG     = 3'd2;
  localparam logic [ZONE_W-1:0] ZONE_MID      = 3'd3;
  localparam logic [ZONE_W-1:0] ZONE_SHORT    = 3'd4;
  localparam logic [ZONE_W-1:0] ZONE_CRITICAL = 3'd5;

  // Beep bands
  localparam logic [1:0] BAND_LONG  = 2'd0;
  localparam logic [1:0] BAND_MID   = 2'd1;
  localparam logic [1:0] BAND_SHORT = 2'd2;
  localparam logic [1:0] BAND_NONE  = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_FAR        = 3'd0;
  localparam logic [2:0] REG_MID        = 3'd1;
  localparam logic [2:0] REG_NEAR       = 3'd2;
  localparam logic [2:0] REG_CRITICAL   = 3'd3;
  localparam logic [2:0] REG_TIMEOUT    = 3'd4;
  localparam logic [2:0] REG_LONG_BEEP  = 3'd5;
  localparam logic [2:0] REG_MID_BEEP   = 3'd6;
  localparam logic [2:0] REG_SHORT_BEEP = 3'd7;

  // Register reset values
  localparam logic [THR_W-1:0]  FAR_RST        = 9'd150;
  localparam logic [THR_W-1:0]  MID_RST        = 9'd100;
  localparam logic [THR_W-1:0]  NEAR_RST       = 9'd70;
  localparam logic [THR_W-1:0]  CRITICAL_RST   = 9'd30;
  localparam logic [TMO_W-1:0]  TIMEOUT_RST    = 16'd17400;
  localparam logic [BEEP_W-1:0] LONG_BEEP_RST  = 10'd600;
  localparam logic [BEEP_W-1:0] MID_BEEP_RST   = 10'd300;
  localparam logic [BEEP_W-1:0] SHORT_BEEP_RST = 10'd20;

  // One result beat
  typedef struct packed {
    logic              trigger;
    logic              buzzer;
    logic              done_res;
    logic [DIST_W-1:0] distance_cm;
    logic              error;
    logic [ZONE_W-1:0] zone;
  } res_t;

  function automatic logic [DIST_W-1:0] median3(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b,
                                                input logic [DIST_W-1:0] c);
    logic [DIST_W-1:0] m;
    if ((a >= b && a <= c) || (a >= c && a <= b)) begin
      m = a;
    end else if ((b >= a && b <= c) || (b >= c && b <= a)) begin
      m = b;
    end else begin
      m = c;
    end
    return m;
  endfunction

endpackage

FILE: sv/ultrasonic_ranger_median_alert.sv
// Ultrasonic ranger: trigger sequencer, echo width in cm, median of three, buzzer zones.
`timescale 1ns / 1ps

// Each accepted echo tick's result beat is registered straight into the output register.
// Throughput: one tick per cycle while in_stall is low; a tick step is one state-to-output pass.
// Echo width is kept directly in cm by a mod-58 sub-counter, so no divider is needed;
// beep length is tracked as ms plus us within the ms, so no multiplier is needed either.
// Reset (synchronous, rst_n low): trigger-low phase, counters zero, buzzer off, registers
// back to defaults, output register empty. Stored samples are not cleared.
module ultrasonic_ranger_median_alert (
  input  logic                         clk,
  input  logic                         rst_n,
  // tick input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_echo,
  // result output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_trigger,
  output logic                         out_buzzer,
  output logic                         out_done_res,
  output logic [ura_pkg::DIST_W-1:0]   out_distance_cm,
  output logic                         out_error,
  output logic [ura_pkg::ZONE_W-1:0]   out_zone,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ura_pkg::ADDR_W-1:0]   paddr,
  input  logic [ura_pkg::DATA_W-1:0]   pwdata,
  output logic [ura_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ura_pkg::THR_W-1:0]  far_r, mid_r, near_r, crit_r;
  logic [ura_pkg::TMO_W-1:0]  tmo_r;
  logic [ura_pkg::BEEP_W-1:0] long_beep_r, mid_beep_r, short_beep_r;
  logic                       wr_en;
  logic [2:0]                 reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ura_pkg::ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      far_r        <= ura_pkg::FAR_RST;
      mid_r        <= ura_pkg::MID_RST;
      near_r       <= ura_pkg::NEAR_RST;
      crit_r       <= ura_pkg::CRITICAL_RST;
      tmo_r        <= ura_pkg::TIMEOUT_RST;
      long_beep_r  <= ura_pkg::LONG_BEEP_RST;
      mid_beep_r   <= ura_pkg::MID_BEEP_RST;
      short_beep_r <= ura_pkg::SHORT_BEEP_RST;
    end else if (wr_en) begin
      case (reg_idx)
        ura_pkg::REG_FAR:        far_r        <= pwdata[ura_pkg::THR_W-1:0];
        ura_pkg::REG_MID:        mid_r        <= pwdata[ura_pkg::THR_W-1:0];
        ura_pkg::REG_NEAR:       near_r       <= pwdata[ura_pkg::THR_W-1:0];
        ura_pkg::REG_CRITICAL:   crit_r       <= pwdata[ura_pkg::THR_W-1:0];
        ura_pkg::REG_TIMEOUT:    tmo_r        <= pwdata[ura_pkg::TMO_W-1:0];
        ura_pkg::REG_LONG_BEEP:  long_beep_r  <= pwdata[ura_pkg::BEEP_W-1:0];
        ura_pkg::REG_MID_BEEP:   mid_beep_r   <= pwdata[ura_pkg::BEEP_W-1:0];
        ura_pkg::REG_SHORT_BEEP: short_beep_r <= pwdata[ura_pkg::BEEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ura_pkg::REG_FAR:        prdata = {{(ura_pkg::DATA_W-ura_pkg::THR_W){1'b0}}, far_r};
      ura_pkg::REG_MID:        prdata = {{(ura_pkg::DATA_W-ura_pkg::THR_W){1'b0}}, mid_r};
      ura_pkg::REG_NEAR:       prdata = {{(ura_pkg::DATA_W-ura_pkg::THR_W){1'b0}}, near_r};
      ura_pkg::REG_CRITICAL:   prdata = {{(ura_pkg::DATA_W-ura_pkg::THR_W){1'b0}}, crit_r};
      ura_pkg::REG_TIMEOUT:    prdata = {{(ura_pkg::DATA_W-ura_pkg::TMO_W){1'b0}}, tmo_r};
      ura_pkg::REG_LONG_BEEP:  prdata = {{(ura_pkg::DATA_W-ura_pkg::BEEP_W){1'b0}}, long_beep_r};
      ura_pkg::REG_MID_BEEP:   prdata = {{(ura_pkg::DATA_W-ura_pkg::BEEP_W){1'b0}}, mid_beep_r};
      ura_pkg::REG_SHORT_BEEP: prdata = {{(ura_pkg::DATA_W-ura_pkg::BEEP_W){1'b0}}, short_beep_r};
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // cnt_r: tick counter for trigger, rise wait and fall wait; in the beep phase
  // its low bits hold the microseconds within the current ms (ms_r).
  // cm_r/sub_r: echo high width so far, as cm and ticks within the cm.
  // q_r: captured widths in cm.
  // ---------------------------------------------------------------------------
  logic [2:0]                   phase_r, phase_nxt;
  logic [ura_pkg::TMO_W-1:0]    cnt_r, cnt_nxt;
  logic [ura_pkg::DIST_W-1:0]   cm_r, cm_nxt;
  logic [ura_pkg::SUB_W-1:0]    sub_r, sub_nxt;
  logic [ura_pkg::BEEP_W-1:0]   ms_r, ms_nxt;
  logic [1:0]                   idx_r, idx_nxt;
  logic                         buzz_lvl_r, buzz_lvl_nxt;
  logic [ura_pkg::DIST_W-1:0]   q_r [ura_pkg::SAMPLES];
  logic [ura_pkg::DIST_W-1:0]   q_nxt [ura_pkg::SAMPLES];

  logic                         accept;
  logic                         out_valid_r;
  ura_pkg::res_t                res_r, res_nxt;

  // Step scratch
  logic [ura_pkg::TMO_W-1:0]    tmo_eff;
  logic [ura_pkg::TMO_W:0]      cnt_inc;
  logic [ura_pkg::US_W-1:0]     us_inc;
  logic [ura_pkg::BEEP_W-1:0]   ms_inc;
  logic [ura_pkg::BEEP_W-1:0]   beep_cur;
  logic [ura_pkg::BEEP_W-1:0]   beep_new;
  logic                         have_sample;
  logic [ura_pkg::DIST_W-1:0]   sample;
  logic [1:0]                   slot;
  logic [ura_pkg::DIST_W-1:0]   med;
  logic [ura_pkg::DIST_W-1:0]   far_x, mid_x, near_x, crit_x;
  logic [1:0]                   band;

  assign tmo_eff = (tmo_r == '0) ? ura_pkg::TMO_W'(1) : tmo_r;
  assign cnt_inc = {1'b0, cnt_r} + (ura_pkg::TMO_W+1)'(1);
  assign far_x   = ura_pkg::DIST_W'(far_r);
  assign mid_x   = ura_pkg::DIST_W'(mid_r);
  assign near_x  = ura_pkg::DIST_W'(near_r);
  assign crit_x  = ura_pkg::DIST_W'(crit_r);

  // beep length of the band parked in idx_r during a beep
  always_comb begin
    case (idx_r)
      ura_pkg::BAND_MID:   beep_cur = mid_beep_r;
      ura_pkg::BAND_SHORT: beep_cur = short_beep_r;
      default:             beep_cur = long_beep_r;
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    cm_nxt       = cm_r;
    sub_nxt      = sub_r;
    ms_nxt       = ms_r;
    idx_nxt      = idx_r;
    buzz_lvl_nxt = buzz_lvl_r;
    q_nxt        = q_r;
    have_sample  = 1'b0;
    sample       = '0;
    slot         = '0;
    med          = '0;
    band         = ura_pkg::BAND_NONE;
    beep_new     = '0;
    us_inc       = '0;
    ms_inc       = '0;
    res_nxt      = '0;
    res_nxt.buzzer = buzz_lvl_r;

    case (phase_r)
      ura_pkg::PH_TRIG_HIGH: begin
        res_nxt.trigger = 1'b1;
        if (cnt_inc >= (ura_pkg::TMO_W+1)'(ura_pkg::TRIG_HIGH_TICKS)) begin
          phase_nxt = ura_pkg::PH_WAIT_RISE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_inc[ura_pkg::TMO_W-1:0];
        end
      end
      ura_pkg::PH_WAIT_RISE: begin
        if (in_echo) begin
          // rising tick counts as the first high tick
          if (tmo_eff == ura_pkg::TMO_W'(1)) begin
            have_sample = 1'b1;
          end else begin
            phase_nxt = ura_pkg::PH_MEASURE;
            cnt_nxt   = ura_pkg::TMO_W'(1);
            cm_nxt    = '0;
            sub_nxt   = ura_pkg::SUB_W'(1);
          end
        end else begin
          cnt_nxt = cnt_inc[ura_pkg::TMO_W-1:0];
          if (cnt_inc >= {1'b0, tmo_eff}) begin
            have_sample = 1'b1;
          end
        end
      end
      ura_pkg::PH_MEASURE: begin
        if (in_echo) begin
          cnt_nxt = cnt_inc[ura_pkg::TMO_W-1:0];
          if (sub_r == ura_pkg::SUB_W'(ura_pkg::US_PER_CM - 1)) begin
            sub_nxt = '0;
            cm_nxt  = cm_r + ura_pkg::DIST_W'(1);
          end else begin
            sub_nxt = sub_r + ura_pkg::SUB_W'(1);
          end
          if (cnt_inc >= {1'b0, tmo_eff}) begin
            have_sample = 1'b1;
          end
        end else begin
          have_sample = 1'b1;
          sample      = cm_r;
        end
      end
      ura_pkg::PH_BEEP: begin
        res_nxt.buzzer = 1'b1;
        if (cnt_r[ura_pkg::US_W-1:0] == ura_pkg::US_W'(ura_pkg::TICKS_PER_MS - 1)) begin
          us_inc = '0;
          ms_inc = ms_r + ura_pkg::BEEP_W'(1);
        end else begin
          us_inc = cnt_r[ura_pkg::US_W-1:0] + ura_pkg::US_W'(1);
          ms_inc = ms_r;
        end
        cnt_nxt = ura_pkg::TMO_W'(us_inc);
        ms_nxt  = ms_inc;
        if (ms_inc >= beep_cur) begin
          buzz_lvl_nxt = 1'b0;
          phase_nxt    = ura_pkg::PH_TRIG_LOW;
          cnt_nxt      = '0;
          ms_nxt       = '0;
          idx_nxt      = '0;
        end
      end
      default: begin
        // trigger low, also taken by unused phase codes
        phase_nxt = ura_pkg::PH_TRIG_LOW;
        if (cnt_inc >= (ura_pkg::TMO_W+1)'(ura_pkg::TRIG_LOW_TICKS)) begin
          phase_nxt = ura_pkg::PH_TRIG_HIGH;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_inc[ura_pkg::TMO_W-1:0];
        end
      end
    endcase

    if (have_sample) begin
      slot        = (idx_r == 2'd3) ? 2'd0 : idx_r;
      q_nxt[slot] = sample;
      idx_nxt     = slot + 2'd1;
      phase_nxt   = ura_pkg::PH_TRIG_LOW;
      cnt_nxt     = '0;
      if (slot == 2'(ura_pkg::SAMPLES - 1)) begin
        // third width completes the set: slot 2 is the fresh sample
        med                 = ura_pkg::median3(q_r[0], q_r[1], sample);
        idx_nxt             = '0;
        res_nxt.done_res    = 1'b1;
        res_nxt.distance_cm = med;
        if (med == '0) begin
          res_nxt.error = 1'b1;
          res_nxt.zone  = ura_pkg::ZONE_ERR;
        end else if (med >= far_x) begin
          res_nxt.zone = ura_pkg::ZONE_FAR;
          buzz_lvl_nxt = 1'b0;
        end else if (med >= mid_x) begin
          res_nxt.zone = ura_pkg::ZONE_LONG;
          band         = ura_pkg::BAND_LONG;
        end else if (med >= near_x) begin
          res_nxt.zone = ura_pkg::ZONE_MID;
          band         = ura_pkg::BAND_MID;
        end else if (med >= crit_x) begin
          res_nxt.zone = ura_pkg::ZONE_SHORT;
          band         = ura_pkg::BAND_SHORT;
        end else begin
          res_nxt.zone = ura_pkg::ZONE_CRITICAL;
          buzz_lvl_nxt = 1'b1;
        end
        res_nxt.buzzer = buzz_lvl_nxt;

        case (band)
          ura_pkg::BAND_LONG:  beep_new = long_beep_r;
          ura_pkg::BAND_MID:   beep_new = mid_beep_r;
          ura_pkg::BAND_SHORT: beep_new = short_beep_r;
          default:             beep_new = '0;
        endcase

        if (band != ura_pkg::BAND_NONE) begin
          buzz_lvl_nxt = 1'b0;
          if (beep_new == '0) begin
            res_nxt.buzzer = 1'b0;
          end else begin
            res_nxt.buzzer = 1'b1;
            // beep runs longer than this single tick
            if (ura_pkg::TICKS_PER_MS > 1 || beep_new > ura_pkg::BEEP_W'(1)) begin
              buzz_lvl_nxt = 1'b1;
              phase_nxt    = ura_pkg::PH_BEEP;
              cnt_nxt      = ura_pkg::TMO_W'(1);
              ms_nxt       = '0;
              idx_nxt      = band;
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Beat handshake: one-deep output register; a tick is taken whenever the
  // register is empty or being drained this cycle.
  // ---------------------------------------------------------------------------
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ura_pkg::PH_TRIG_LOW;
      cnt_r       <= '0;
      cm_r        <= '0;
      sub_r       <= '0;
      ms_r        <= '0;
      idx_r       <= '0;
      buzz_lvl_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r    <= phase_nxt;
        cnt_r      <= cnt_nxt;
        cm_r       <= cm_nxt;
        sub_r      <= sub_nxt;
        ms_r       <= ms_nxt;
        idx_r      <= idx_nxt;
        buzz_lvl_r <= buzz_lvl_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      q_r   <= q_nxt;
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_trigger     = res_r.trigger;
  assign out_buzzer      = res_r.buzzer;
  assign out_done_res    = res_r.done_res;
  assign out_distance_cm = res_r.distance_cm;
  assign out_error       = res_r.error;
  assign out_zone        = res_r.zone;

`ifndef NO_ASSERTIONS
  // while a beep runs the held buzzer level is high
  a_beep_level: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ura_pkg::PH_BEEP) |-> buzz_lvl_r)
    else $error("beep phase with buzzer level low");

  // a distance is never reported on a trigger-high tick
  a_done_no_trig: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> !out_trigger)
    else $error("done beat with trigger high");

  // error flag and error zone agree on a done beat
  a_err_zone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> (out_error == (out_zone == ura_pkg::ZONE_ERR)))
    else $error("error flag and zone disagree");

  // non-done beats carry no distance
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_done_res) |->
      (out_distance_cm == '0 && !out_error && out_zone == ura_pkg::ZONE_ERR))
    else $error("distance fields set without done");

  // sample slot never rests on the unused code
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (idx_r != 2'd3))
    else $error("sample index out of range");
`endif

endmodule

FILE: sim/ultrasonic_ranger_median_alert_tb.sv
// Self-checking testbench for the ultrasonic ranger: scripted opening ticks, then echo episodes.
`timescale 1ns / 1ps

module ultrasonic_ranger_median_alert_tb;
  import ura_pkg::*;

  // ---------------------------------------------------------------------------
  // Opening script: the first ticks after reset with reset register values.
  // Each row is one tick; its result is known by inspection, so it is typed in
  // rather than predicted. Echo during the trigger phases must be ignored.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic echo;
    logic trig;
  } script_row_t;

  localparam int OPENING_LEN = 17;
  localparam script_row_t OPENING [0:OPENING_LEN-1] = '{
    '{1'b1, 1'b0},  // trigger low, echo ignored
    '{1'b0, 1'b0},  // trigger low, second tick
    '{1'b1, 1'b1},  // trigger high x10, echo noise ignored
    '{1'b0, 1'b1},
    '{1'b1, 1'b1},
    '{1'b0, 1'b1},
    '{1'b0, 1'b1},
    '{1'b1, 1'b1},
    '{1'b1, 1'b1},
    '{1'b0, 1'b1},
    '{1'b1, 1'b1},
    '{1'b0, 1'b1},
    '{1'b0, 1'b0},  // waiting for rise
    '{1'b1, 1'b0},  // rise: first high tick
    '{1'b1, 1'b0},
    '{1'b1, 1'b0},
    '{1'b0, 1'b0}   // fall: first sample of 3 ticks stored, no median yet
  };

  // ---------------------------------------------------------------------------
  // Register settings walked after the opening. Each set runs until the given
  // number of medians has been produced. Extremes: thresholds 0 and 400,
  // timeout 0 / 1 / 65535, beep lengths 0 and 1000 (the latter only where no
  // beep band can be reached, so the run stays short).
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [THR_W-1:0]  far_cm;
    logic [THR_W-1:0]  mid_cm;
    logic [THR_W-1:0]  near_cm;
    logic [THR_W-1:0]  critical_cm;
    logic [TMO_W-1:0]  timeout_us;
    logic [BEEP_W-1:0] long_ms;
    logic [BEEP_W-1:0] mid_ms;
    logic [BEEP_W-1:0] short_ms;
    logic [7:0]        medians;
  } range_set_t;

  localparam int SET_COUNT = 8;
  localparam range_set_t RANGE_SETS [0:SET_COUNT-1] = '{
    // ordinary bands, mid beep of 0 ms just clears the buzzer
    '{9'd4,   9'd3,   9'd2,   9'd1,   16'd400,   10'd1,    10'd0,    10'd2,    8'd12},
    // misordered thresholds: priority order decides
    '{9'd2,   9'd5,   9'd3,   9'd1,   16'd300,   10'd1,    10'd1,    10'd1,    8'd6},
    // everything below 400: critical, buzzer held on
    '{9'd400, 9'd400, 9'd400, 9'd400, 16'd350,   10'd1,    10'd1,    10'd1,    8'd4},
    // zero timeout acts as one: error medians, buzzer left as it is
    '{9'd400, 9'd400, 9'd400, 9'd400, 16'd0,     10'd1,    10'd1,    10'd1,    8'd3},
    '{9'd0,   9'd0,   9'd0,   9'd0,   16'd1,     10'd1,    10'd1,    10'd1,    8'd3},
    // longest timeout, longest beeps, but every non-zero distance is far
    '{9'd1,   9'd0,   9'd0,   9'd0,   16'd65535, 10'd1000, 10'd1000, 10'd1000, 8'd4},
    // short timeout: many fall timeouts
    '{9'd3,   9'd2,   9'd1,   9'd0,   16'd60,    10'd0,    10'd1,    10'd0,    8'd6},
    '{9'd6,   9'd4,   9'd2,   9'd1,   16'd500,   10'd2,    10'd1,    10'd1,    8'd12}
  };

  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no beat on either side

  // DUT signals
  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_echo;
  logic                out_valid;
  logic                out_stall;
  logic                out_trigger;
  logic                out_buzzer;
  logic                out_done_res;
  logic [DIST_W-1:0]   out_distance_cm;
  logic                out_error;
  logic [ZONE_W-1:0]   out_zone;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Predicted ranger state and register copy
  logic [2:0]        ranger_phase;
  int                ranger_ticks;
  logic [1:0]        ranger_slot;
  int                echo_widths [0:SAMPLES-1];
  logic              ranger_buzz;
  logic [THR_W-1:0]  lim_far;
  logic [THR_W-1:0]  lim_mid;
  logic [THR_W-1:0]  lim_near;
  logic [THR_W-1:0]  lim_critical;
  logic [TMO_W-1:0]  echo_timeout;
  logic [BEEP_W-1:0] beep_ms [0:2];

  // Scoreboard
  res_t beats_due [$];
  res_t beat_want;
  int   faults;
  int   beats_seen;
  int   medians_seen;
  int   idle_cycles;
  int   stall_left;
  bit   calm;  // no idling on either side while set

  // Current echo plan for the next sample
  int   plan_delay;
  int   plan_width;
  bit   plan_noisy;

  ultrasonic_ranger_median_alert uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_echo         (in_echo),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_trigger     (out_trigger),
    .out_buzzer      (out_buzzer),
    .out_done_res    (out_done_res),
    .out_distance_cm (out_distance_cm),
    .out_error       (out_error),
    .out_zone        (out_zone),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_fault(input string msg);
    faults++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // One tick of the ranger: sequencer step, sample capture, median and zone.
  task automatic advance_ranger(input logic echo_lvl, output res_t beat);
    int         tmo_eff;
    int         smp;
    int         len;
    int         a;
    int         b;
    int         c;
    int         lo;
    int         hi;
    int         d;
    int         slot;
    bit         sampled;
    logic [1:0] band;
    beat = '0;
    beat.zone = ZONE_ERR;
    beat.buzzer = ranger_buzz;
    tmo_eff = (echo_timeout == '0) ? 1 : int'(echo_timeout);
    sampled = 1'b0;
    smp = 0;
    case (ranger_phase)
      PH_TRIG_HIGH: begin
        beat.trigger = 1'b1;
        ranger_ticks++;
        if (ranger_ticks >= TRIG_HIGH_TICKS) begin
          ranger_phase = PH_WAIT_RISE;
          ranger_ticks = 0;
        end
      end
      PH_WAIT_RISE: begin
        // rise tick counts as the first high tick
        ranger_ticks = echo_lvl ? 1 : ranger_ticks + 1;
        if (ranger_ticks >= tmo_eff) sampled = 1'b1;
        else if (echo_lvl) ranger_phase = PH_MEASURE;
      end
      PH_MEASURE: begin
        if (echo_lvl) begin
          ranger_ticks++;
          if (ranger_ticks >= tmo_eff) sampled = 1'b1;
        end else begin
          sampled = 1'b1;
          smp = ranger_ticks & 16'hFFFF;
        end
      end
      PH_BEEP: begin
        beat.buzzer = 1'b1;
        ranger_ticks++;
        len = int'(beep_ms[int'(ranger_slot) % 3]) * TICKS_PER_MS;
        if (ranger_ticks >= len) begin
          ranger_buzz = 1'b0;
          ranger_phase = PH_TRIG_LOW;
          ranger_ticks = 0;
          ranger_slot = '0;
        end
      end
      default: begin
        ranger_phase = PH_TRIG_LOW;
        ranger_ticks++;
        if (ranger_ticks >= TRIG_LOW_TICKS) begin
          ranger_phase = PH_TRIG_HIGH;
          ranger_ticks = 0;
        end
      end
    endcase

    if (sampled) begin
      slot = (ranger_slot < SAMPLES) ? int'(ranger_slot) : 0;
      echo_widths[slot] = smp;
      ranger_slot = 2'(slot + 1);
      ranger_phase = PH_TRIG_LOW;
      ranger_ticks = 0;
      if (ranger_slot >= SAMPLES) begin
        a = echo_widths[0] / US_PER_CM;
        b = echo_widths[1] / US_PER_CM;
        c = echo_widths[2] / US_PER_CM;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        d = (c < lo) ? lo : ((c > hi) ? hi : c);
        band = BAND_NONE;
        ranger_slot = '0;
        beat.done_res = 1'b1;
        beat.distance_cm = (d > 2047) ? 11'd2047 : DIST_W'(d);
        if (d == 0) begin
          // error: buzzer untouched
          beat.error = 1'b1;
          beat.zone = ZONE_ERR;
        end else if (d >= lim_far) begin
          beat.zone = ZONE_FAR;
          ranger_buzz = 1'b0;
        end else if (d >= lim_mid) begin
          beat.zone = ZONE_LONG;
          band = BAND_LONG;
        end else if (d >= lim_near) begin
          beat.zone = ZONE_MID;
          band = BAND_MID;
        end else if (d >= lim_critical) begin
          beat.zone = ZONE_SHORT;
          band = BAND_SHORT;
        end else begin
          beat.zone = ZONE_CRITICAL;
          ranger_buzz = 1'b1;
        end
        beat.buzzer = ranger_buzz;
        if (band != BAND_NONE) begin
          len = int'(beep_ms[band]) * TICKS_PER_MS;
          ranger_buzz = 1'b0;
          beat.buzzer = (len != 0);
          if (len > 1) begin
            // blocking beep starts on the done tick
            ranger_buzz = 1'b1;
            ranger_phase = PH_BEEP;
            ranger_ticks = 1;
            ranger_slot = band;
          end
        end
      end
    end
  endtask

  // Present one echo tick, wait for it to be taken, then book its result.
  task automatic drive_tick(input logic echo_lvl, input bit pinned, input res_t pinned_beat);
    int   gap;
    int   roll;
    res_t beat;
    roll = $urandom_range(0, 99);
    if (calm || roll < 65) gap = 0;
    else if (roll < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_echo  <= 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_echo  <= echo_lvl;
    do @(posedge clk); while (in_stall !== 1'b0);
    advance_ranger(echo_lvl, beat);
    if (beat.done_res) medians_seen++;
    beats_due.push_back(pinned ? pinned_beat : beat);
  endtask

  // Register write: setup then access phase; pready is tied high in the block.
  task automatic write_reg(input logic [2:0] idx, input int unsigned value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_FAR:        lim_far = value[THR_W-1:0];
      REG_MID:        lim_mid = value[THR_W-1:0];
      REG_NEAR:       lim_near = value[THR_W-1:0];
      REG_CRITICAL:   lim_critical = value[THR_W-1:0];
      REG_TIMEOUT:    echo_timeout = value[TMO_W-1:0];
      REG_LONG_BEEP:  beep_ms[BAND_LONG] = value[BEEP_W-1:0];
      REG_MID_BEEP:   beep_ms[BAND_MID] = value[BEEP_W-1:0];
      REG_SHORT_BEEP: beep_ms[BAND_SHORT] = value[BEEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop sending and let every booked result come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Result checker: every accepted beat against the oldest booked one.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (beats_due.size() == 0) begin
        note_fault($sformatf("beat %0d arrived with nothing due", beats_seen));
      end else begin
        beat_want = beats_due.pop_front();
        if (out_trigger !== beat_want.trigger)
          note_fault($sformatf("beat %0d trigger: got %b want %b",
                               beats_seen, out_trigger, beat_want.trigger));
        if (out_buzzer !== beat_want.buzzer)
          note_fault($sformatf("beat %0d buzzer: got %b want %b",
                               beats_seen, out_buzzer, beat_want.buzzer));
        if (out_done_res !== beat_want.done_res)
          note_fault($sformatf("beat %0d done_res: got %b want %b",
                               beats_seen, out_done_res, beat_want.done_res));
        if (out_distance_cm !== beat_want.distance_cm)
          note_fault($sformatf("beat %0d distance_cm: got %0d want %0d",
                               beats_seen, out_distance_cm, beat_want.distance_cm));
        if (out_error !== beat_want.error)
          note_fault($sformatf("beat %0d error: got %b want %b",
                               beats_seen, out_error, beat_want.error));
        if (out_zone !== beat_want.zone)
          note_fault($sformatf("beat %0d zone: got %0d want %0d",
                               beats_seen, out_zone, beat_want.zone));
      end
      beats_seen++;
    end
  end

  // Receiver back-pressure: mostly short stalls, the odd long one, none when calm.
  initial begin
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && !calm) begin
        if ($urandom_range(0, 99) < 20) stall_left = $urandom_range(1, 3);
        else if ($urandom_range(0, 99) < 4) stall_left = $urandom_range(8, 40);
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int   p;
    int   i;
    int   roll;
    int   cm_hi;
    int   target;
    res_t pinned;
    logic tick_echo;

    // all inputs known from time zero
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_echo  = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    calm     = 1'b0;
    faults   = 0;
    beats_seen   = 0;
    medians_seen = 0;
    plan_delay = 0;
    plan_width = 1;
    plan_noisy = 1'b0;

    // predicted state after reset
    ranger_phase = PH_TRIG_LOW;
    ranger_ticks = 0;
    ranger_slot  = '0;
    ranger_buzz  = 1'b0;
    for (i = 0; i < SAMPLES; i++) echo_widths[i] = 0;
    lim_far      = FAR_RST;
    lim_mid      = MID_RST;
    lim_near     = NEAR_RST;
    lim_critical = CRITICAL_RST;
    echo_timeout = TIMEOUT_RST;
    beep_ms[BAND_LONG]  = LONG_BEEP_RST;
    beep_ms[BAND_MID]   = MID_BEEP_RST;
    beep_ms[BAND_SHORT] = SHORT_BEEP_RST;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Opening ticks with reset registers; results typed in, no idling
    calm = 1'b1;
    for (i = 0; i < OPENING_LEN; i++) begin
      pinned = '0;
      pinned.trigger = OPENING[i].trig;
      pinned.zone = ZONE_ERR;
      drive_tick(OPENING[i].echo, 1'b1, pinned);
    end

    // Register sets, each followed by echo episodes. Registers change only once
    // every booked result has come back, and never in the middle of a beep.
    for (p = 0; p < SET_COUNT; p++) begin
      drain_results();
      calm = (p % 3 == 1);
      write_reg(REG_FAR,        RANGE_SETS[p].far_cm);
      write_reg(REG_MID,        RANGE_SETS[p].mid_cm);
      write_reg(REG_NEAR,       RANGE_SETS[p].near_cm);
      write_reg(REG_CRITICAL,   RANGE_SETS[p].critical_cm);
      write_reg(REG_TIMEOUT,    RANGE_SETS[p].timeout_us);
      write_reg(REG_LONG_BEEP,  RANGE_SETS[p].long_ms);
      write_reg(REG_MID_BEEP,   RANGE_SETS[p].mid_ms);
      write_reg(REG_SHORT_BEEP, RANGE_SETS[p].short_ms);

      // distances to aim at: a little past the far threshold, kept small
      cm_hi  = (int'(lim_far) + 1 > 7) ? 7 : int'(lim_far) + 1;
      target = medians_seen + int'(RANGE_SETS[p].medians);
      while (medians_seen < target || ranger_phase == PH_BEEP) begin
        // Plan the next echo while the trigger pulse is out: mostly a clean
        // pulse of chosen width, sometimes a rise or fall timeout, sometimes noise.
        if (ranger_phase == PH_TRIG_HIGH) begin
          roll = $urandom_range(0, 99);
          plan_noisy = (roll < 5);
          plan_delay = $urandom_range(0, 10);
          plan_width = $urandom_range(0, cm_hi) * US_PER_CM + $urandom_range(0, US_PER_CM - 1);
          if (echo_timeout <= 600) begin
            if (roll >= 5 && roll < 12) plan_delay = int'(echo_timeout) + $urandom_range(0, 3);
            else if (roll >= 12 && roll < 20)
              plan_width = int'(echo_timeout) + $urandom_range(0, 3);
          end
        end
        case (ranger_phase)
          PH_WAIT_RISE: begin
            if (plan_noisy) tick_echo = 1'($urandom_range(0, 1));
            else tick_echo = (ranger_ticks >= plan_delay);
          end
          PH_MEASURE: begin
            if (plan_noisy) tick_echo = 1'($urandom_range(0, 1));
            else tick_echo = (ranger_ticks < plan_width);
          end
          // echo is ignored here; stray highs test that
          default: tick_echo = ($urandom_range(0, 9) == 0);
        endcase
        drive_tick(tick_echo, 1'b0, '0);
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (faults == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
